[rtl/dag_longest_path_through_vertex_core_macros.svh]
// assertion macros for the longest path core
`ifndef DAG_LONGEST_PATH_THROUGH_VERTEX_CORE_MACROS_SVH
`define DAG_LONGEST_PATH_THROUGH_VERTEX_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define DLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define DLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DLP_ASSERT_NOW(lbl, ante, cons, msg)
`define DLP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/dlp_pkg.sv]
package dlp_pkg;

    // default sizes
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;

    // fixed field widths
    localparam int VID_W  = 6;
    localparam int VCNT_W = 7;
    localparam int EDGE_W = 2 * VID_W;

    localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd64;

    // request codes
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic clr_k;
        logic inc_k;
        logic init_wr;
        logic edge_rd;
        logic chk;
        logic len_rd;
        logic emit_rd;
        logic upd;
        logic pass_inc;
        logic out_load;
        logic finish_clr;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic k_at_edges;
        logic k_at_n;
        logic k_last;
        logic pass_done;
        logic out_free;
    } sts_t;

endpackage

[rtl/dlp_ifs.sv]
// request channel
interface dlp_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [dlp_pkg::VID_W-1:0] edge_from;
    logic [dlp_pkg::VID_W-1:0] edge_to;

    modport source (output valid, req_type, edge_from, edge_to, input ready);
    modport sink (input valid, req_type, edge_from, edge_to, output ready);
endinterface

// result channel
interface dlp_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [dlp_pkg::VID_W-1:0]  vertex_index;
    logic [dlp_pkg::VCNT_W-1:0] through_length;
    logic                       edges_dropped;
    logic                       last_result;

    modport source (output valid, vertex_index, through_length, edges_dropped, last_result,
                    input ready);
    modport sink (input valid, vertex_index, through_length, edges_dropped, last_result,
                  output ready);
endinterface

[rtl/dag_longest_path_through_vertex_core.sv]
// Longest path through each vertex of a directed acyclic graph. Add-edge
// requests are taken one per cycle while the block is idle and stored in an
// edge memory (capacity MAX_EDGES); out-of-range or overflow edges are dropped
// and flagged. A finish request stops input while the block initializes the
// lengths, range-checks each stored edge, then runs N - 1 relaxation passes
// (N vertices) that each walk the single-port edge memory, then emits one
// result per vertex in index order, each once the result register is free.
// The edge store and drop flag clear after the last result is loaded.
// vertex_count may only be written while the block is idle.
module dag_longest_path_through_vertex_core
#(
    parameter int MAX_VERTICES = dlp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = dlp_pkg::MAX_EDGES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [dlp_pkg::VCNT_W-1:0] cfg_wdata,
    dlp_req_if.sink                    req,
    dlp_rsp_if.source                  rsp
);

    dlp_pkg::cmd_t cmd;
    dlp_pkg::sts_t sts;

    // sequencer
    dlp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and arithmetic
    dlp_datapath
    #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    )
    u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .edge_from          (req.edge_from),
        .edge_to            (req.edge_to),
        .out_valid          (rsp.valid),
        .out_ready          (rsp.ready),
        .out_vertex_index   (rsp.vertex_index),
        .out_through_length (rsp.through_length),
        .out_edges_dropped  (rsp.edges_dropped),
        .out_last_result    (rsp.last_result)
    );

endmodule

[rtl/dlp_ctrl.sv]
module dlp_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_type,
    output logic          req_ready,
    input  dlp_pkg::sts_t sts,
    output dlp_pkg::cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_INIT    = 10'b0000000010,
        ST_CHK_RD  = 10'b0000000100,
        ST_CHK_EV  = 10'b0000001000,
        ST_PASS    = 10'b0000010000,
        ST_RX_RD   = 10'b0000100000,
        ST_RX_LEN  = 10'b0001000000,
        ST_RX_UPD  = 10'b0010000000,
        ST_EM_RD   = 10'b0100000000,
        ST_EM_LD   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == dlp_pkg::REQ_FINISH)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_INIT:
            begin
                if (sts.k_at_n)
                begin
                    cmd.clr_k  = 1'b1;
                    state_next = ST_CHK_RD;
                end
                else
                begin
                    cmd.init_wr = 1'b1;
                    cmd.inc_k   = 1'b1;
                end
            end
            ST_CHK_RD:
            begin
                if (sts.k_at_edges)
                begin
                    cmd.clr_k  = 1'b1;
                    state_next = ST_PASS;
                end
                else
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = ST_CHK_EV;
                end
            end
            ST_CHK_EV:
            begin
                cmd.chk    = 1'b1;
                cmd.inc_k  = 1'b1;
                state_next = ST_CHK_RD;
            end
            ST_PASS:
            begin
                cmd.clr_k  = 1'b1;
                state_next = sts.pass_done ? ST_EM_RD : ST_RX_RD;
            end
            ST_RX_RD:
            begin
                if (sts.k_at_edges)
                begin
                    cmd.pass_inc = 1'b1;
                    state_next   = ST_PASS;
                end
                else
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = ST_RX_LEN;
                end
            end
            ST_RX_LEN:
            begin
                cmd.len_rd = 1'b1;
                state_next = ST_RX_UPD;
            end
            ST_RX_UPD:
            begin
                cmd.upd    = 1'b1;
                cmd.inc_k  = 1'b1;
                state_next = ST_RX_RD;
            end
            ST_EM_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EM_LD;
            end
            ST_EM_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.k_last)
                    begin
                        cmd.finish_clr = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cmd.inc_k  = 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/dlp_datapath.sv]
`include "dag_longest_path_through_vertex_core_macros.svh"

module dlp_datapath
#(
    parameter int MAX_VERTICES = dlp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = dlp_pkg::MAX_EDGES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dlp_pkg::cmd_t               cmd,
    output dlp_pkg::sts_t               sts,
    input  logic                        cfg_we,
    input  logic [dlp_pkg::VCNT_W-1:0]  cfg_wdata,
    input  logic [dlp_pkg::VID_W-1:0]   edge_from,
    input  logic [dlp_pkg::VID_W-1:0]   edge_to,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dlp_pkg::VID_W-1:0]   out_vertex_index,
    output logic [dlp_pkg::VCNT_W-1:0]  out_through_length,
    output logic                        out_edges_dropped,
    output logic                        out_last_result
);

    localparam int VW  = $clog2(MAX_VERTICES + 1);
    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = (EW > VW) ? EW : VW;
    localparam int IW  = dlp_pkg::VID_W;
    localparam int XW  = dlp_pkg::VCNT_W;

    localparam logic [XW-1:0] MAXV_X = XW'(MAX_VERTICES);
    localparam logic [EW-1:0] MAXE   = EW'(MAX_EDGES);

    // configuration and counters
    logic [XW-1:0] vcnt_reg;
    logic [VW-1:0] n_eff;
    logic [EW-1:0] total_reg;
    logic          drop_reg;
    logic [CW-1:0] k_reg;
    logic [VW-1:0] pass_reg;

    // memories
    logic [dlp_pkg::EDGE_W-1:0] edge_mem [MAX_EDGES];
    logic [VW-1:0]              fwd_mem  [MAX_VERTICES];
    logic [VW-1:0]              bwd_mem  [MAX_VERTICES];

    logic [dlp_pkg::EDGE_W-1:0] edge_reg;
    logic [VW-1:0]              fq0_reg, fq1_reg, bq0_reg, bq1_reg;

    // output register
    logic              ov_reg;
    logic [IW-1:0]     oidx_reg;
    logic [XW-1:0]     olen_reg;
    logic              odrop_reg;
    logic              olast_reg;

    logic [IW-1:0] e_a, e_b, in_a, in_b;
    logic          e_ok, in_ok;
    logic [AW-1:0] a_addr, b_addr, k_addr;
    logic [VW:0]   cand_f, cand_b, sum_t;
    logic [VW-1:0] cf, cb, tl;

    // effective vertex count
    always_comb
    begin
        if (vcnt_reg == '0)
        begin
            n_eff = VW'(1);
        end
        else if (vcnt_reg > MAXV_X)
        begin
            n_eff = VW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = VW'(vcnt_reg);
        end
    end

    // range checks
    assign e_a   = edge_reg[dlp_pkg::EDGE_W-1:IW];
    assign e_b   = edge_reg[IW-1:0];
    assign in_a  = edge_from;
    assign in_b  = edge_to;
    assign e_ok  = ({1'b0, e_a} < XW'(n_eff)) && ({1'b0, e_b} < XW'(n_eff));
    assign in_ok = ({1'b0, in_a} < XW'(n_eff)) && ({1'b0, in_b} < XW'(n_eff));
    assign a_addr = e_a[AW-1:0];
    assign b_addr = e_b[AW-1:0];
    assign k_addr = k_reg[AW-1:0];

    // status
    assign sts.k_at_edges = (k_reg == CW'(total_reg));
    assign sts.k_at_n     = (k_reg == CW'(n_eff));
    assign sts.k_last     = ((k_reg + CW'(1)) == CW'(n_eff));
    assign sts.pass_done  = (pass_reg >= n_eff);
    assign sts.out_free   = !ov_reg || out_ready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg  <= dlp_pkg::VCOUNT_RESET;
            total_reg <= '0;
            drop_reg  <= 1'b0;
            k_reg     <= '0;
            pass_reg  <= VW'(1);
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcnt_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                if (!in_ok || (total_reg == MAXE))
                begin
                    drop_reg <= 1'b1;
                end
                else
                begin
                    total_reg <= total_reg + EW'(1);
                end
            end
            if (cmd.chk && !e_ok)
            begin
                drop_reg <= 1'b1;
            end
            if (cmd.finish_clr)
            begin
                total_reg <= '0;
                drop_reg  <= 1'b0;
            end
            if (cmd.start || cmd.clr_k)
            begin
                k_reg <= '0;
            end
            else if (cmd.inc_k)
            begin
                k_reg <= k_reg + CW'(1);
            end
            if (cmd.start)
            begin
                pass_reg <= VW'(1);
            end
            else if (cmd.pass_inc)
            begin
                pass_reg <= pass_reg + VW'(1);
            end
            if (cmd.out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (cmd.load && in_ok && (total_reg != MAXE))
        begin
            edge_mem[total_reg[EIW-1:0]] <= {in_a, in_b};
        end
        if (cmd.edge_rd)
        begin
            edge_reg <= edge_mem[k_reg[EIW-1:0]];
        end
    end

    // candidate lengths, saturated at the vertex count
    assign cand_f = {1'b0, fq0_reg} + (VW+1)'(1);
    assign cand_b = {1'b0, bq0_reg} + (VW+1)'(1);
    assign cf     = (cand_f > {1'b0, n_eff}) ? n_eff : cand_f[VW-1:0];
    assign cb     = (cand_b > {1'b0, n_eff}) ? n_eff : cand_b[VW-1:0];

    // forward length memory
    always_ff @(posedge clk)
    begin
        if (cmd.init_wr)
        begin
            fwd_mem[k_addr] <= VW'(1);
        end
        else if (cmd.upd && e_ok && (cf > fq1_reg))
        begin
            fwd_mem[a_addr] <= cf;
        end
        if (cmd.len_rd || cmd.emit_rd)
        begin
            fq0_reg <= fwd_mem[cmd.emit_rd ? k_addr : b_addr];
            fq1_reg <= fwd_mem[a_addr];
        end
    end

    // backward length memory
    always_ff @(posedge clk)
    begin
        if (cmd.init_wr)
        begin
            bwd_mem[k_addr] <= VW'(1);
        end
        else if (cmd.upd && e_ok && (cb > bq1_reg))
        begin
            bwd_mem[b_addr] <= cb;
        end
        if (cmd.len_rd || cmd.emit_rd)
        begin
            bq0_reg <= bwd_mem[cmd.emit_rd ? k_addr : a_addr];
            bq1_reg <= bwd_mem[b_addr];
        end
    end

    // through length
    assign sum_t = {1'b0, fq0_reg} + {1'b0, bq0_reg} - (VW+1)'(1);
    assign tl    = (sum_t > {1'b0, n_eff}) ? n_eff : sum_t[VW-1:0];

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            oidx_reg  <= IW'(k_reg);
            olen_reg  <= XW'(tl);
            odrop_reg <= drop_reg;
            olast_reg <= sts.k_last;
        end
    end

    assign out_valid          = ov_reg;
    assign out_vertex_index   = oidx_reg;
    assign out_through_length = olen_reg;
    assign out_edges_dropped  = odrop_reg;
    assign out_last_result    = olast_reg;

    `DLP_ASSERT_NOW(a_total_bound, 1'b1, total_reg <= MAXE, "edge count above capacity")
    `DLP_ASSERT_NEXT(a_out_loaded, cmd.out_load, ov_reg, "result not presented after load")
    `DLP_ASSERT_NOW(a_init_range, cmd.init_wr, k_reg < CW'(n_eff), "init beyond vertex count")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int EDGE_CAP    = dlp_pkg::MAX_EDGES_DEF;
    localparam int VERT_CAP    = dlp_pkg::MAX_VERTICES_DEF;
    localparam int QUIET_LIMIT = 250000;
    localparam int ITEM_TARGET = 380;
    localparam int CALM_START  = 330;

    typedef struct {
        logic                      kind;
        logic [dlp_pkg::VID_W-1:0] src;
        logic [dlp_pkg::VID_W-1:0] dst;
    } request_t;

    typedef struct {
        logic [dlp_pkg::VID_W-1:0]  vertex;
        logic [dlp_pkg::VCNT_W-1:0] length;
        logic                       dropped;
        logic                       last;
    } vertex_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [dlp_pkg::VCNT_W-1:0] cfg_wdata;

    dlp_req_if req_ch ();
    dlp_rsp_if rsp_ch ();

    dag_longest_path_through_vertex_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    // pending requests and expected per-vertex results
    request_t       pending_q[$];
    vertex_result_t path_results_q[$];

    // shadow state of the graph engine
    logic [dlp_pkg::VCNT_W-1:0] shadow_count;
    logic [dlp_pkg::VID_W-1:0]  stored_src [EDGE_CAP];
    logic [dlp_pkg::VID_W-1:0]  stored_dst [EDGE_CAP];
    int                         stored_total;
    logic                       shadow_drop;

    bit calm;
    bit failed;
    int queued;
    int quiet_cycles;
    int req_gap;
    int rsp_stall;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // apply one transfer to the shadow graph, queue results on finish
    task automatic apply_request(input request_t r);
        int n;
        int f_len [VERT_CAP];
        int b_len [VERT_CAP];
        int a;
        int b;
        int t;
        vertex_result_t res;
        n = int'(shadow_count);
        if (n < 1) n = 1;
        if (n > VERT_CAP) n = VERT_CAP;
        if (r.kind == dlp_pkg::REQ_ADD)
        begin
            if (int'(r.src) >= n || int'(r.dst) >= n || stored_total >= EDGE_CAP)
            begin
                shadow_drop = 1'b1;
            end
            else
            begin
                stored_src[stored_total] = r.src;
                stored_dst[stored_total] = r.dst;
                stored_total++;
            end
        end
        else
        begin
            for (int k = 0; k < stored_total; k++)
            begin
                if (int'(stored_src[k]) >= n || int'(stored_dst[k]) >= n) shadow_drop = 1'b1;
            end
            for (int k = 0; k < n; k++)
            begin
                f_len[k] = 1;
                b_len[k] = 1;
            end
            // relaxation passes, lengths saturate at the vertex count
            for (int p = 1; p < n; p++)
            begin
                for (int k = 0; k < stored_total; k++)
                begin
                    a = int'(stored_src[k]);
                    b = int'(stored_dst[k]);
                    if (a < n && b < n)
                    begin
                        t = f_len[b] + 1;
                        if (t > n) t = n;
                        if (t > f_len[a]) f_len[a] = t;
                        t = b_len[a] + 1;
                        if (t > n) t = n;
                        if (t > b_len[b]) b_len[b] = t;
                    end
                end
            end
            for (int k = 0; k < n; k++)
            begin
                t = f_len[k] + b_len[k] - 1;
                if (t > n) t = n;
                res.vertex  = k[dlp_pkg::VID_W-1:0];
                res.length  = t[dlp_pkg::VCNT_W-1:0];
                res.dropped = shadow_drop;
                res.last    = (k + 1 == n);
                path_results_q = {path_results_q, res};
            end
            stored_total = 0;
            shadow_drop  = 1'b0;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        request_t r;
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.req_type  <= dlp_pkg::REQ_ADD;
            req_ch.edge_from <= '0;
            req_ch.edge_to   <= '0;
            req_gap          <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_gap != 0)
            begin
                req_ch.valid <= 1'b0;
                req_gap      <= req_gap - 1;
            end
            else if (pending_q.size() > 0)
            begin
                r = pending_q.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.req_type  <= r.kind;
                req_ch.edge_from <= r.src;
                req_ch.edge_to   <= r.dst;
                if (!calm && $urandom_range(0, 5) == 0) req_gap <= int'($urandom_range(1, 4));
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result ready with random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= 0;
        end
        else if (rsp_stall != 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= rsp_stall - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) rsp_stall <= int'($urandom_range(1, 4));
        end
    end

    // monitor: predict on request transfer, compare on result transfer
    always @(posedge clk)
    begin : monitor
        request_t r;
        vertex_result_t e;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                r.kind = req_ch.req_type;
                r.src  = req_ch.edge_from;
                r.dst  = req_ch.edge_to;
                apply_request(r);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (path_results_q.size() == 0)
                begin
                    $error("unexpected result for vertex %0d", rsp_ch.vertex_index);
                    failed = 1'b1;
                end
                else
                begin
                    e = path_results_q.pop_front();
                    if (rsp_ch.vertex_index !== e.vertex)
                    begin
                        $error("vertex_index exp %0d got %0d", e.vertex, rsp_ch.vertex_index);
                        failed = 1'b1;
                    end
                    if (rsp_ch.through_length !== e.length)
                    begin
                        $error("through_length exp %0d got %0d", e.length,
                               rsp_ch.through_length);
                        failed = 1'b1;
                    end
                    if (rsp_ch.edges_dropped !== e.dropped)
                    begin
                        $error("edges_dropped exp %0d got %0d", e.dropped,
                               rsp_ch.edges_dropped);
                        failed = 1'b1;
                    end
                    if (rsp_ch.last_result !== e.last)
                    begin
                        $error("last_result exp %0d got %0d", e.last, rsp_ch.last_result);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("dag_longest_path_through_vertex_core: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_edge(input int a, input int b);
        request_t r;
        r.kind = dlp_pkg::REQ_ADD;
        r.src  = a[dlp_pkg::VID_W-1:0];
        r.dst  = b[dlp_pkg::VID_W-1:0];
        pending_q = {pending_q, r};
        queued++;
    endtask

    task automatic queue_finish();
        request_t r;
        r.kind = dlp_pkg::REQ_FINISH;
        r.src  = dlp_pkg::VID_W'($urandom_range(0, 63));
        r.dst  = dlp_pkg::VID_W'($urandom_range(0, 63));
        pending_q = {pending_q, r};
        queued++;
    endtask

    // wait until every request is taken and every result has come back
    task automatic drain();
        @(negedge clk);
        while (pending_q.size() != 0 || req_ch.valid || path_results_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(input int v);
        drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[dlp_pkg::VCNT_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_count = v[dlp_pkg::VCNT_W-1:0];
    endtask

    // stimulus
    initial
    begin : stimulus
        int v;
        int n;
        int m;
        int a;
        int b;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        shadow_count = dlp_pkg::VCOUNT_RESET;
        stored_total = 0;
        shadow_drop  = 1'b0;
        calm         = 1'b0;
        failed       = 1'b0;
        queued       = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset vertex count, extreme endpoints
        queue_edge(0, 1);
        queue_edge(1, 63);
        queue_edge(62, 63);
        queue_edge(63, 0);
        queue_finish();
        // zero count acts as one vertex, self loop kept, edge from vertex 1 dropped
        write_count(0);
        queue_edge(0, 0);
        queue_edge(1, 0);
        queue_finish();
        // oversized count acts as maximum
        write_count(127);
        queue_edge(63, 62);
        queue_edge(5, 63);
        queue_finish();
        // count lowered after loading drops stored edges at finish
        write_count(64);
        queue_edge(10, 40);
        queue_edge(1, 2);
        queue_edge(2, 3);
        write_count(20);
        queue_finish();
        // single vertex, empty graph
        write_count(1);
        queue_finish();
        // store full with a small vertex set
        write_count(4);
        for (int k = 0; k < EDGE_CAP + 2; k++)
        begin
            queue_edge(int'($urandom_range(0, 3)), int'($urandom_range(0, 3)));
        end
        queue_finish();

        // random graphs, mostly well-formed DAGs
        while (queued < ITEM_TARGET)
        begin
            if (queued > CALM_START) calm = 1'b1;
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 7))
                    0:       v = 64;
                    1:       v = int'($urandom_range(0, 127));
                    default: v = int'($urandom_range(2, 12));
                endcase
                write_count(v);
            end
            n = int'(shadow_count);
            if (n < 1) n = 1;
            if (n > VERT_CAP) n = VERT_CAP;
            m = int'($urandom_range(0, 16));
            for (int k = 0; k < m; k++)
            begin
                if (n >= 2 && $urandom_range(0, 9) < 8)
                begin
                    a = int'($urandom_range(0, n - 2));
                    b = int'($urandom_range(a + 1, n - 1));
                end
                else
                begin
                    a = int'($urandom_range(0, 63));
                    b = int'($urandom_range(0, 63));
                end
                queue_edge(a, b);
            end
            queue_finish();
            if ($urandom_range(0, 4) == 0) drain();
        end

        drain();
        repeat (50) @(posedge clk);
        if (!failed && path_results_q.size() == 0)
            $display("dag_longest_path_through_vertex_core: match");
        else
            $display("dag_longest_path_through_vertex_core: mismatch");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/dlp_pkg.sv
rtl/dlp_ifs.sv
rtl/dlp_ctrl.sv
rtl/dlp_datapath.sv
rtl/dag_longest_path_through_vertex_core.sv
tb/tb_top.sv
